[rtl/slr_pkg.sv]
// Package for the sorted list insertion sorter.
// Holds op/status codes, cell commands and shared widths.
// No dependencies.
package slr_pkg;

  localparam int DepthDef = 32;
  localparam int MaxOut   = 32;
  localparam int ValW     = 32;
  localparam int PosW     = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DUMP   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t              cmd;
    logic signed [ValW-1:0] key;
  } cell_ctl_t;

endpackage

[rtl/slr_cell.sv]
// One cell of the sorted chain: a value, its valid bit and the compare.
// Depends on slr_pkg.
module slr_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  slr_pkg::cell_ctl_t              ctl_i,
  input  logic signed [slr_pkg::ValW-1:0] prev_val_i,
  input  logic                            prev_valid_i,
  input  logic                            prev_gt_i,
  input  logic signed [slr_pkg::ValW-1:0] next_val_i,
  input  logic                            next_valid_i,
  input  logic signed [slr_pkg::ValW-1:0] head_val_i,
  output logic signed [slr_pkg::ValW-1:0] val_o,
  output logic                            valid_o,
  output logic                            gt_o,
  output logic                            take_o
);

  logic signed [slr_pkg::ValW-1:0] val_r, val_nxt;
  logic                            valid_r, valid_nxt;
  logic                            gt, take;

  assign gt   = valid_r && (val_r > ctl_i.key);
  assign take = (gt || !valid_r) && prev_valid_i && !prev_gt_i;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    case (ctl_i.cmd)
      slr_pkg::CMD_INSERT: begin
        if (prev_gt_i) begin
          val_nxt = prev_val_i;
        end else if (take) begin
          val_nxt = ctl_i.key;
        end
        valid_nxt = valid_r | prev_gt_i | take;
      end
      slr_pkg::CMD_ROTATE: begin
        // last valid cell wraps around to the head
        if (valid_r) begin
          val_nxt = next_valid_i ? next_val_i : head_val_i;
        end
      end
      slr_pkg::CMD_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
        val_nxt   = val_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o   = val_r;
  assign valid_o = valid_r;
  assign gt_o    = gt;
  assign take_o  = take;

endmodule

[rtl/sorted_list_insertion_sorter.sv]
// Top level of the sorted list insertion sorter: cell chain, control FSM, output register.
// Depends on slr_pkg and slr_cell.
//
//   channel | direction | handshake       | payload
//   in_     | input     | in_valid/stall  | op, value
//   out_    | output    | out_valid/stall | value_out, position, last, status
//
// Insert and clear are applied on acceptance; every cell compares against the key in parallel.
// Dump, once accepted, rotates the valid prefix of the chain through cell 0, one entry per cycle
// while the output is not stalled; an empty list gives a single ST_EMPTY beat; the list is back in place.
// Reset clears the valid bits, the count and the FSM.
// An output stall holds the result register and stalls the input and the rotation.
module sorted_list_insertion_sorter #(
  parameter int DEPTH = slr_pkg::DepthDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_op,
  input  logic signed [slr_pkg::ValW-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [slr_pkg::ValW-1:0] out_value_out,
  output logic [slr_pkg::PosW-1:0]        out_position,
  output logic                            out_last,
  output logic [1:0]                      out_status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   step_r, step_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic signed [slr_pkg::ValW-1:0] out_value_r, out_value_nxt;
  logic [slr_pkg::PosW-1:0]        out_pos_r, out_pos_nxt;
  logic                            out_last_r, out_last_nxt;
  slr_pkg::status_t                out_status_r, out_status_nxt;

  slr_pkg::cell_ctl_t              ctl;
  slr_pkg::op_t                    op;
  logic                            out_free, in_acc, full, emit_ok, dump_go;
  logic [CW-1:0]                   emit_n;
  logic [IW-1:0]                   ins_pos;

  logic signed [slr_pkg::ValW-1:0] val_w [DEPTH];
  logic [DEPTH-1:0]                valid_w, gt_w, take_w;

  assign op       = slr_pkg::op_t'(in_op);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign emit_n   = (32'(count_r) > 32'(slr_pkg::MaxOut)) ? CW'(slr_pkg::MaxOut) : count_r;
  assign emit_ok  = 32'(step_r) < 32'(slr_pkg::MaxOut);
  assign dump_go  = (state_r == S_DUMP) && (out_free || !emit_ok);

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [slr_pkg::ValW-1:0] prev_val, next_val;
    logic                            prev_valid, prev_gt, next_valid;
    if (i == 0) begin : g_first
      assign prev_val   = ctl.key;
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_val   = val_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_gt    = gt_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_val   = val_w[0];
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_val   = val_w[i+1];
      assign next_valid = valid_w[i+1];
    end
    slr_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (ctl),
      .prev_val_i   (prev_val),
      .prev_valid_i (prev_valid),
      .prev_gt_i    (prev_gt),
      .next_val_i   (next_val),
      .next_valid_i (next_valid),
      .head_val_i   (val_w[0]),
      .val_o        (val_w[i]),
      .valid_o      (valid_w[i]),
      .gt_o         (gt_w[i]),
      .take_o       (take_w[i])
    );
  end

  // one-hot insert slot to rank
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (take_w[i]) begin
        ins_pos = ins_pos | IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    ctl.cmd        = slr_pkg::CMD_HOLD;
    ctl.key        = in_value;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op)
            slr_pkg::OP_INSERT: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = in_value;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_pos_nxt    = '0;
                out_status_nxt = slr_pkg::ST_FULL;
              end else begin
                ctl.cmd        = slr_pkg::CMD_INSERT;
                count_nxt      = count_r + CW'(1);
                out_pos_nxt    = slr_pkg::PosW'(ins_pos);
                out_status_nxt = slr_pkg::ST_OK;
              end
            end
            slr_pkg::OP_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_pos_nxt    = '0;
                out_last_nxt   = 1'b1;
                out_status_nxt = slr_pkg::ST_EMPTY;
              end else begin
                step_nxt  = '0;
                state_nxt = S_DUMP;
              end
            end
            slr_pkg::OP_CLEAR: begin
              ctl.cmd   = slr_pkg::CMD_CLEAR;
              count_nxt = '0;
            end
            default: begin
              ctl.cmd = slr_pkg::CMD_HOLD;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (dump_go) begin
          ctl.cmd = slr_pkg::CMD_ROTATE;
          if (emit_ok) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = val_w[0];
            out_pos_nxt    = slr_pkg::PosW'(step_r);
            out_last_nxt   = (step_r == emit_n - CW'(1));
            out_status_nxt = slr_pkg::ST_OK;
          end
          if (step_r == count_r - CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_position  = out_pos_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;

endmodule

[rtl/slr_checker.sv]
// Port-level checks for the sorted list insertion sorter, bound to the top level.
// Depends on slr_pkg.
module slr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [slr_pkg::ValW-1:0] out_value_out,
  input logic [slr_pkg::PosW-1:0]        out_position,
  input logic                            out_last,
  input logic [1:0]                      out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_out) && $stable(out_position))
    else $error("stalled output beat changed");

  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == slr_pkg::ST_FULL) |-> out_last)
    else $error("full status beat not last");

  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == slr_pkg::ST_EMPTY) |-> out_last && (out_position == '0))
    else $error("empty status beat malformed");

  a_dump_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_position == slr_pkg::PosW'($past(out_position) + 1'b1)))
    else $error("dump beats not consecutive");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken during dump");

endmodule

bind sorted_list_insertion_sorter slr_checker u_slr_checker (.*);
